// ----- rtl/core/vl2n_pkg.sv -----
package vl2n_pkg;

  localparam int MAX_DIMS_DEF = 64;

  localparam int CNT_W  = 7;
  localparam int ELEM_W = 16;
  localparam int SUM_W  = 37;
  localparam int NORM_W = 19;
  localparam int ITER_W = 5;
  localparam int QUO_W  = 16;

  localparam logic [CNT_W-1:0]  DIMS_RESET    = 7'd64;
  localparam logic [ITER_W-1:0] SQRT_ITERS_M1 = 5'd18;
  localparam logic [ITER_W-1:0] DIV_ITERS_M1  = 5'd15;

  // Program steps of the sequencer.
  typedef enum logic [3:0] {
    S_WAIT,
    S_SQR,
    S_CHK,
    S_SQRT,
    S_READ,
    S_LOAD,
    S_DIV,
    S_EMIT,
    S_CLR
  } step_t;

  // Jump conditions: when the condition holds the sequencer goes to the
  // target step, otherwise to the next step.
  typedef enum logic [2:0] {
    C_NEVER,
    C_IDLE,
    C_NOTFULL,
    C_ITER,
    C_NOTLAST,
    C_ALWAYS
  } cond_t;

  typedef struct packed {
    logic  take;
    logic  sq_acc;
    logic  sqrt_init;
    logic  sqrt_step;
    logic  rd;
    logic  ld;
    logic  div_step;
    logic  emit;
    logic  clr;
    cond_t cond;
    step_t tgt;
  } ucode_t;

  typedef struct packed {
    logic full;
    logic iter_nz;
    logic last;
  } status_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '0;
    case (s)
      S_WAIT: begin
        w.take = 1'b1;
        w.cond = C_IDLE;
        w.tgt  = S_WAIT;
      end
      S_SQR: begin
        w.sq_acc = 1'b1;
        w.cond   = C_NEVER;
        w.tgt    = S_WAIT;
      end
      S_CHK: begin
        w.sqrt_init = 1'b1;
        w.cond      = C_NOTFULL;
        w.tgt       = S_WAIT;
      end
      S_SQRT: begin
        w.sqrt_step = 1'b1;
        w.cond      = C_ITER;
        w.tgt       = S_SQRT;
      end
      S_READ: begin
        w.rd   = 1'b1;
        w.cond = C_NEVER;
        w.tgt  = S_WAIT;
      end
      S_LOAD: begin
        w.ld   = 1'b1;
        w.cond = C_NEVER;
        w.tgt  = S_WAIT;
      end
      S_DIV: begin
        w.div_step = 1'b1;
        w.cond     = C_ITER;
        w.tgt      = S_DIV;
      end
      S_EMIT: begin
        w.emit = 1'b1;
        w.cond = C_NOTLAST;
        w.tgt  = S_READ;
      end
      S_CLR: begin
        w.clr  = 1'b1;
        w.cond = C_ALWAYS;
        w.tgt  = S_WAIT;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.tgt  = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/vl2n_sequencer.sv -----
module vl2n_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  vl2n_pkg::status_t status,
  output vl2n_pkg::ucode_t  word
);
  import vl2n_pkg::*;

  step_t pc, pc_next;
  logic  jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    word = ucode_rom(pc);
    case (word.cond)
      C_NEVER:   jump = 1'b0;
      C_IDLE:    jump = !start;
      C_NOTFULL: jump = !status.full;
      C_ITER:    jump = status.iter_nz;
      C_NOTLAST: jump = !status.last;
      C_ALWAYS:  jump = 1'b1;
      default:   jump = 1'b1;
    endcase
    pc_next = jump ? word.tgt : step_t'(pc + 4'd1);
  end

endmodule

// ----- rtl/core/vl2n_datapath.sv -----
module vl2n_datapath #(
  parameter int MAX_DIMS = vl2n_pkg::MAX_DIMS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [vl2n_pkg::ELEM_W-1:0]     element_value,
  input  logic                                   cfg_valid,
  input  logic        [vl2n_pkg::CNT_W-1:0]      cfg_data,
  input  vl2n_pkg::ucode_t                       word,
  output vl2n_pkg::status_t                      status,
  output logic                                   result_valid,
  output logic signed [vl2n_pkg::ELEM_W-1:0]     normalized_value,
  output logic                                   last_of_vector
);
  import vl2n_pkg::*;

  localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIMS);
  localparam logic [SUM_W-1:0] SQRT_TOP = SUM_W'(1) << (2 * ((SUM_W - 1) / 2));

  logic                     accept;
  logic [CNT_W-1:0]         dims, dims_eff, count, addr;
  logic signed [ELEM_W-1:0] elem;
  logic signed [2*ELEM_W-1:0] sq;
  logic [ELEM_W-1:0]        mem [MAX_DIMS];
  logic [ELEM_W-1:0]        rd_data;
  logic [SUM_W-1:0]         sum, sqv, root, sbit, trial;
  logic [NORM_W-1:0]        norm, rem;
  logic [ELEM_W:0]          mag_w;
  logic                     neg, ovf;
  logic [ELEM_W-1:0]        dvd;
  logic [QUO_W-1:0]         quo;
  logic [ITER_W-1:0]        iter;
  logic [NORM_W:0]          shifted;
  logic [ELEM_W-1:0]        res;

  assign accept = word.take && start;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= DIMS_RESET;
    end else if (cfg_valid) begin
      dims <= cfg_data;
    end
  end

  always_comb begin
    if (dims == '0) begin
      dims_eff = CNT_W'(1);
    end else if (dims > MAX_CNT) begin
      dims_eff = MAX_CNT;
    end else begin
      dims_eff = dims;
    end
  end

  // Element store: written on accept, read one registered word per element.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[count[IDX_W-1:0]] <= element_value;
    end
    if (word.rd) begin
      rd_data <= mem[addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elem <= element_value;
    end
  end

  assign sq = elem * elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (word.sq_acc) begin
      sum   <= sum + SUM_W'($unsigned(sq));
      count <= count + CNT_W'(1);
    end else if (word.clr) begin
      sum   <= '0;
      count <= '0;
    end
  end

  // Square root, one result bit per step from two bits of the radicand.
  assign trial = root + sbit;
  assign norm  = root[NORM_W-1:0];

  always_ff @(posedge clk) begin
    if (word.sqrt_init) begin
      sqv  <= sum + SUM_W'(1);
      root <= '0;
      sbit <= SQRT_TOP;
    end else if (word.sqrt_step) begin
      if (sqv >= trial) begin
        sqv  <= sqv - trial;
        root <= (root >> 1) + sbit;
      end else begin
        root <= root >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (word.sqrt_init) begin
      iter <= SQRT_ITERS_M1;
    end else if (word.ld) begin
      iter <= DIV_ITERS_M1;
    end else if (word.sqrt_step || word.div_step) begin
      iter <= iter - ITER_W'(1);
    end
  end

  // Division of |element| * 2^15 by the norm. A quotient of 2^16 or more
  // only saturates, so that case is flagged up front and the divider
  // produces just the low sixteen quotient bits.
  assign mag_w = rd_data[ELEM_W-1] ? ((ELEM_W+1)'(1) << ELEM_W) - {1'b0, rd_data}
                                    : {1'b0, rd_data};
  assign shifted = {rem, dvd[ELEM_W-1]};

  always_ff @(posedge clk) begin
    if (word.ld) begin
      neg <= rd_data[ELEM_W-1];
      ovf <= (NORM_W+1)'(mag_w) >= {norm, 1'b0};
      rem <= NORM_W'(mag_w >> 1);
      dvd <= {mag_w[0], {(ELEM_W-1){1'b0}}};
      quo <= '0;
    end else if (word.div_step) begin
      if (shifted >= {1'b0, norm}) begin
        rem <= NORM_W'(shifted - {1'b0, norm});
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= shifted[NORM_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dvd <= {dvd[ELEM_W-2:0], 1'b0};
    end
  end

  always_comb begin
    if (neg) begin
      if (ovf || quo > 16'd32768) begin
        res = 16'h8000;
      end else begin
        res = 16'd0 - quo;
      end
    end else begin
      if (ovf || quo[QUO_W-1]) begin
        res = 16'h7FFF;
      end else begin
        res = quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= word.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (word.emit) begin
      normalized_value <= res;
      last_of_vector   <= status.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (word.sqrt_init) begin
      addr <= '0;
    end else if (word.emit) begin
      addr <= addr + CNT_W'(1);
    end
  end

  assign status.full    = count >= dims_eff;
  assign status.iter_nz = iter != '0;
  assign status.last    = (addr + CNT_W'(1)) == count;

endmodule

// ----- rtl/core/vector_l2_normalizer_core.sv -----
// Channel  | Signals                                     | Handshake
// ---------+---------------------------------------------+----------------------------
// input    | start, busy, element_value                  | taken when start & !busy
// result   | result_valid, normalized_value, last_of_... | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_data              | written when valid & ready
//
// Each element word is stored when accepted, then its square is accumulated.
// On the final element of a vector the square root is set up and iterates, then
// each result takes a memory read, a load, 16 divider steps and an emit, the
// divider giving one quotient bit per cycle; a clear step closes the vector.
// Reset is synchronous; the element store has no reset. Results cannot be
// stalled, and busy stays high from an accepted word until the block is free.
// Configuration is taken only while the block is idle.
module vector_l2_normalizer_core #(
  parameter int MAX_DIMS = vl2n_pkg::MAX_DIMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [vl2n_pkg::ELEM_W-1:0] element_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [vl2n_pkg::CNT_W-1:0]  cfg_data,
  output logic                               result_valid,
  output logic signed [vl2n_pkg::ELEM_W-1:0] normalized_value,
  output logic                               last_of_vector
);
  import vl2n_pkg::*;

  ucode_t  word;
  status_t status;

  vl2n_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .word   (word)
  );

  vl2n_datapath #(
    .MAX_DIMS (MAX_DIMS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .element_value    (element_value),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .word             (word),
    .status           (status),
    .result_valid     (result_valid),
    .normalized_value (normalized_value),
    .last_of_vector   (last_of_vector)
  );

  assign busy      = !word.take;
  assign cfg_ready = word.take;

endmodule

// ----- rtl/core/vl2n_checker.sv -----
module vl2n_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic last_of_vector
);

  // An accepted word always keeps the block occupied for the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an accepted word");

  // Results only appear while the block is occupied with a vector.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe while idle");

  // Results of one vector are spaced apart by the divider.
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on adjacent cycles");

  // The final result shows during the closing cycle, and the block is free
  // on the cycle after it.
  a_last_close: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_vector |=> !busy)
    else $error("block still busy after the last result");

endmodule

bind vector_l2_normalizer_core vl2n_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .result_valid   (result_valid),
  .last_of_vector (last_of_vector)
);
